// ===== hdl/srd_pkg.sv =====
// srd_pkg: shared types and constants of the spike rate detector.
// Register indexes, reset values, coefficient bundles, fixed field widths.
// No dependencies.
package srd_pkg;

	localparam int CFG_W       = 32;
	localparam int IDX_W       = 3;
	localparam int THR_W       = 24;
	localparam int BLEN_W      = 16;
	localparam int COEF_W      = 32;
	localparam int Y_W         = 32;
	localparam int SPK_W       = 16;
	localparam int SUM_W       = 18;
	localparam int FILL_OUT_W  = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_BIN_LENGTH = 3'd1,
		REG_COEF_B0    = 3'd2,
		REG_COEF_B1    = 3'd3,
		REG_COEF_B2    = 3'd4,
		REG_COEF_A1    = 3'd5,
		REG_COEF_A2    = 3'd6
	} reg_idx_t;

	localparam logic signed [THR_W-1:0]  THRESHOLD_RST  = -24'sd24488;
	localparam logic        [BLEN_W-1:0] BIN_LENGTH_RST = 16'd1500;
	localparam logic signed [COEF_W-1:0] COEF_B0_RST    = 32'sd258678568;
	localparam logic signed [COEF_W-1:0] COEF_B1_RST    = -32'sd517357135;
	localparam logic signed [COEF_W-1:0] COEF_B2_RST    = 32'sd258678568;
	localparam logic signed [COEF_W-1:0] COEF_A1_RST    = -32'sd517002385;
	localparam logic signed [COEF_W-1:0] COEF_A2_RST    = 32'sd249276436;

	localparam logic signed [Y_W-1:0] Y_MAX = 32'sh7fff_ffff;
	localparam logic signed [Y_W-1:0] Y_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
	} ff_coef_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} fb_coef_t;

endpackage

// ===== hdl/srd_front.sv =====
// srd_front: input side of the detector. Takes samples, keeps x history and
// forms the feed-forward sum b0*x + b1*x1 + b2*x2 over two stages.
// Depends on srd_pkg.
module srd_front #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srd_pkg::ff_coef_t             coef,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic signed [SAMPLE_BITS+srd_pkg::COEF_W+1:0] q_data
);

	localparam int PROD_W = SAMPLE_BITS + srd_pkg::COEF_W;
	localparam int FF_W   = PROD_W + 2;

	logic signed [SAMPLE_BITS-1:0] x1_q, x2_q;
	logic signed [PROD_W-1:0]      p0, p1, p2;
	logic signed [PROD_W-1:0]      p0_s1, p1_s1, p2_s1;
	logic signed [FF_W-1:0]        ff_s2;
	logic                          valid_s1, valid_s2;
	logic                          adv1, adv2, load2, take;

	assign adv2     = valid_s2 && q_ready;
	assign load2    = !valid_s2 || adv2;
	assign adv1     = valid_s1 && load2;
	assign in_ready = !valid_s1 || adv1;
	assign take     = in_valid && in_ready;

	assign p0 = coef.b0 * sample;
	assign p1 = coef.b1 * x1_q;
	assign p2 = coef.b2 * x2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q     <= '0;
			x2_q     <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				x1_q <= sample;
				x2_q <= x1_q;
			end
			if (take)
				valid_s1 <= 1'b1;
			else if (adv1)
				valid_s1 <= 1'b0;
			if (adv1)
				valid_s2 <= 1'b1;
			else if (adv2)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0_s1 <= p0;
			p1_s1 <= p1;
			p2_s1 <= p2;
		end
		if (adv1)
			ff_s2 <= FF_W'(p0_s1) + FF_W'(p1_s1) + FF_W'(p2_s1);
	end

	assign q_valid = valid_s2;
	assign q_data  = ff_s2;

endmodule

// ===== hdl/srd_fifo.sv =====
// srd_fifo: small register queue between the front and back ends.
// Holds feed-forward sums so either side can stall on its own.
// No dependencies.
module srd_fifo #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with pointers apart");

endmodule

// ===== hdl/srd_back.sv =====
// srd_back: back end of the detector. Closes the biquad feedback, rounds and
// clamps y, then detects crossings, counts bins and keeps the window ring.
// Depends on srd_pkg.
module srd_back #(
	parameter int WINDOW_BINS    = 4,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srd_pkg::fb_coef_t                   coef,
	input  logic signed [srd_pkg::THR_W-1:0]    threshold,
	input  logic        [srd_pkg::BLEN_W-1:0]   bin_length,
	input  logic                                q_valid,
	output logic                                q_ready,
	input  logic signed [SAMPLE_BITS+srd_pkg::COEF_W+1:0] q_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [srd_pkg::SUM_W-1:0]      spike_total,
	output logic        [srd_pkg::FILL_OUT_W-1:0] bins_filled
);

	localparam int FF_W   = SAMPLE_BITS + srd_pkg::COEF_W + 2;
	localparam int FB_W   = 2 * srd_pkg::COEF_W;
	localparam int ACC_W  = ((FF_W > FB_W + 2) ? FF_W : FB_W + 2) + 1;
	localparam int Y_LSB  = COEF_FRAC_BITS;
	localparam int Y_MSB  = COEF_FRAC_BITS + srd_pkg::Y_W - 1;
	localparam int SLOT_W = $clog2(WINDOW_BINS);
	localparam int FILL_W = $clog2(WINDOW_BINS + 1);
	localparam int SPK_W  = srd_pkg::SPK_W;
	localparam int SUM_W  = srd_pkg::SUM_W;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	// feedback stage
	logic signed [srd_pkg::Y_W-1:0] y1_q, y2_q, y_sat, y_s1;
	logic signed [FB_W-1:0]         fb1, fb2;
	logic signed [ACC_W-1:0]        acc;
	logic [ACC_W-1:Y_MSB]           acc_hi;
	logic                           valid_s1, pop, adv_b;

	assign fb1    = coef.a1 * y1_q;
	assign fb2    = coef.a2 * y2_q;
	assign acc    = ACC_W'(q_data) - ACC_W'(fb1) - ACC_W'(fb2) + ROUND;
	assign acc_hi = acc[ACC_W-1:Y_MSB];

	always_comb begin
		if ((&acc_hi) || !(|acc_hi))
			y_sat = acc[Y_MSB:Y_LSB];
		else if (acc[ACC_W-1])
			y_sat = srd_pkg::Y_MIN;
		else
			y_sat = srd_pkg::Y_MAX;
	end

	assign q_ready = !valid_s1 || adv_b;
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q     <= '0;
			y2_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				y1_q <= y_sat;
				y2_q <= y1_q;
			end
			if (pop)
				valid_s1 <= 1'b1;
			else if (adv_b)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			y_s1 <= y_sat;
	end

	// bin stage
	logic [SPK_W-1:0]  ring_q [WINDOW_BINS];
	logic [SPK_W-1:0]  bin_spikes_q, spikes_nx, ring_old;
	logic [srd_pkg::BLEN_W-1:0] bin_samples_q, samples_nx;
	logic [SLOT_W-1:0] ring_slot_q;
	logic [FILL_W-1:0] fill_q, fill_nx;
	logic [SUM_W-1:0]  running_total_q, total_nx;
	logic [SUM_W-1:0]  spike_total_q;
	logic [srd_pkg::FILL_OUT_W-1:0] bins_filled_q;
	logic              was_above_q, above, close, ring_full, out_valid_q;

	assign adv_b      = valid_s1 && (!out_valid_q || out_ready);
	assign above      = y_s1 > srd_pkg::Y_W'(threshold);
	assign spikes_nx  = bin_spikes_q + SPK_W'(above && !was_above_q);
	assign samples_nx = bin_samples_q + 1'b1;
	assign close      = samples_nx >= bin_length;
	assign ring_full  = fill_q == FILL_W'(WINDOW_BINS);
	assign ring_old   = ring_q[ring_slot_q];
	assign fill_nx    = ring_full ? fill_q : fill_q + 1'b1;
	assign total_nx   = running_total_q + SUM_W'(spikes_nx)
		- (ring_full ? SUM_W'(ring_old) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_above_q     <= 1'b0;
			bin_spikes_q    <= '0;
			bin_samples_q   <= '0;
			ring_slot_q     <= '0;
			fill_q          <= '0;
			running_total_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (adv_b) begin
				was_above_q <= above;
				if (close) begin
					bin_spikes_q    <= '0;
					bin_samples_q   <= '0;
					running_total_q <= total_nx;
					fill_q          <= fill_nx;
					ring_slot_q     <= (ring_slot_q == SLOT_W'(WINDOW_BINS - 1)) ?
						'0 : ring_slot_q + 1'b1;
				end else begin
					bin_spikes_q  <= spikes_nx;
					bin_samples_q <= samples_nx;
				end
			end
			if (adv_b && close)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b && close) begin
			ring_q[ring_slot_q] <= spikes_nx;
			spike_total_q       <= total_nx;
			bins_filled_q       <= srd_pkg::FILL_OUT_W'(fill_nx);
		end
	end

	assign out_valid   = out_valid_q;
	assign spike_total = spike_total_q;
	assign bins_filled = bins_filled_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_BINS))
		else $error("bin fill count beyond window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_slot_q <= SLOT_W'(WINDOW_BINS - 1))
		else $error("ring slot beyond window");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_b && close |=> bin_samples_q == '0 && bin_spikes_q == '0 && out_valid_q)
		else $error("bin close left counters or result behind");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> fill_q != '0)
		else $error("result with no bins filled");

endmodule

// ===== hdl/spike_rate_detector_core.sv =====
// spike_rate_detector_core: top level of the spike rate detector.
// Holds the configuration registers; instantiates srd_front, srd_fifo, srd_back.
// Depends on srd_pkg.
//
//   channel  signals                          direction  beat
//   cfg      cfg_we, cfg_index, cfg_data      in         one register write
//   in       in_valid, in_ready, sample       in         one Q16.8 sample
//   out      out_valid, out_ready,            out        one closed bin
//            spike_total, bins_filled
//
// Sustains one sample per cycle when nothing is stalled; a result is presented
// once the closing sample has passed both front stages, the queue and y_s1.
// The biquad feedback closes combinationally in the back end: two 32x32 products,
// one wide sum, round and clamp.
// Reset clears control and filter history; ring entries are written before read.
// out_ready low stalls the back end; the 4-entry queue and two front stages
// fill before in_ready drops.
module spike_rate_detector_core #(
	parameter int WINDOW_BINS    = 4,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [srd_pkg::IDX_W-1:0]          cfg_index,
	input  logic [srd_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [srd_pkg::SUM_W-1:0]          spike_total,
	output logic [srd_pkg::FILL_OUT_W-1:0]     bins_filled
);

	localparam int FF_W = SAMPLE_BITS + srd_pkg::COEF_W + 2;

	logic signed [srd_pkg::THR_W-1:0]  threshold_q;
	logic        [srd_pkg::BLEN_W-1:0] bin_length_q;
	srd_pkg::ff_coef_t                 ff_coef_q;
	srd_pkg::fb_coef_t                 fb_coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= srd_pkg::THRESHOLD_RST;
			bin_length_q <= srd_pkg::BIN_LENGTH_RST;
			ff_coef_q.b0 <= srd_pkg::COEF_B0_RST;
			ff_coef_q.b1 <= srd_pkg::COEF_B1_RST;
			ff_coef_q.b2 <= srd_pkg::COEF_B2_RST;
			fb_coef_q.a1 <= srd_pkg::COEF_A1_RST;
			fb_coef_q.a2 <= srd_pkg::COEF_A2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srd_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data[srd_pkg::THR_W-1:0];
				srd_pkg::REG_BIN_LENGTH: bin_length_q <= cfg_data[srd_pkg::BLEN_W-1:0];
				srd_pkg::REG_COEF_B0:    ff_coef_q.b0 <= cfg_data;
				srd_pkg::REG_COEF_B1:    ff_coef_q.b1 <= cfg_data;
				srd_pkg::REG_COEF_B2:    ff_coef_q.b2 <= cfg_data;
				srd_pkg::REG_COEF_A1:    fb_coef_q.a1 <= cfg_data;
				srd_pkg::REG_COEF_A2:    fb_coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                   push_valid, push_ready, pop_valid, pop_ready;
	logic signed [FF_W-1:0] push_data, pop_data;

	srd_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (ff_coef_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.q_valid  (push_valid),
		.q_ready  (push_ready),
		.q_data   (push_data)
	);

	srd_fifo #(
		.WIDTH (FF_W),
		.DEPTH (srd_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	srd_back #(
		.WINDOW_BINS    (WINDOW_BINS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (fb_coef_q),
		.threshold   (threshold_q),
		.bin_length  (bin_length_q),
		.q_valid     (pop_valid),
		.q_ready     (pop_ready),
		.q_data      (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.spike_total (spike_total),
		.bins_filled (bins_filled)
	);

endmodule
